/* hdl/sysex_fv_pkg.sv */
// Shared constants and types for the SysEx frame validator.
package sysex_fv_pkg;

    localparam logic [7:0] SX_START      = 8'hF0;
    localparam logic [7:0] SX_END        = 8'hF7;
    localparam logic [3:0] MIN_END_INDEX = 4'd9;
    localparam logic [3:0] SUM_FIRST     = 4'd5;
    localparam logic [3:0] INDEX_MAX     = 4'd15;
    localparam logic [3:0] IDX_MANUF     = 4'd1;
    localparam logic [3:0] IDX_MODEL     = 4'd3;
    localparam logic [3:0] IDX_COMMAND   = 4'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_IDS     = 3'd2;
    localparam logic [2:0] ST_BAD_SUM     = 3'd3;
    localparam logic [2:0] ST_UNHANDLED   = 3'd4;

    localparam logic [1:0] CFG_MANUF_ID   = 2'd0;
    localparam logic [1:0] CFG_MODEL_ID   = 2'd1;
    localparam logic [1:0] CFG_SET_CMD    = 2'd2;

    localparam logic [6:0] RST_MANUF_ID   = 7'd65;
    localparam logic [6:0] RST_MODEL_ID   = 7'd20;
    localparam logic [6:0] RST_SET_CMD    = 7'd18;

    typedef struct packed {
        logic [6:0] manufacturer_id;
        logic [6:0] model_id;
        logic [6:0] set_command;
    } t_cfg;

    typedef struct packed {
        logic [2:0] status;
        logic       accepted;
        logic [7:0] addr_high;
        logic [7:0] addr_mid;
        logic [7:0] addr_low;
        logic [7:0] data_value;
    } t_result;

endpackage

/* hdl/sysex_fv_byte_if.sv */
// Handshake channel carrying received MIDI bytes.
interface sysex_fv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

/* hdl/sysex_fv_result_if.sv */
// Handshake channel carrying one frame verdict with its address and value bytes.
interface sysex_fv_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       accepted;
    logic [7:0] addr_high;
    logic [7:0] addr_mid;
    logic [7:0] addr_low;
    logic [7:0] data_value;

    modport source(output valid, output status, output accepted, output addr_high,
                   output addr_mid, output addr_low, output data_value, input ready);
    modport sink(input valid, input status, input accepted, input addr_high,
                 input addr_mid, input addr_low, input data_value, output ready);
endinterface

/* hdl/sysex_fv_cfg_if.sv */
// Register write channel for the validator's configuration.
interface sysex_fv_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

/* hdl/sysex_fv_tracker.sv */
// Frame state tracker: index, identity checks, running checksum and field capture.
module sysex_fv_tracker
    import sysex_fv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_fire,
    output t_result    o_result
);

    logic       r_in_frame,      n_in_frame;
    logic [3:0] r_byte_index,    n_byte_index;
    logic       r_ids_bad,       n_ids_bad;
    logic [7:0] r_command_byte,  n_command_byte;
    logic [7:0] r_field_bytes [4];
    logic [7:0] n_field_bytes [4];
    logic [6:0] r_running_sum,   n_running_sum;
    logic [7:0] r_previous_byte, n_previous_byte;

    logic [6:0] expect_sum;
    logic [2:0] status;
    logic [1:0] field_sel;

    assign expect_sum = 7'(7'd0 - r_running_sum);
    assign field_sel  = 2'(r_byte_index - SUM_FIRST);

    always_comb begin
        if (r_byte_index < MIN_END_INDEX) begin
            status = ST_TOO_SHORT;
        end else if (r_ids_bad) begin
            status = ST_BAD_IDS;
        end else if (r_previous_byte != {1'b0, expect_sum}) begin
            status = ST_BAD_SUM;
        end else if (r_command_byte != {1'b0, i_cfg.set_command}) begin
            status = ST_UNHANDLED;
        end else begin
            status = ST_OK;
        end
        o_result.status     = status;
        o_result.accepted   = (status == ST_OK);
        o_result.addr_high  = r_field_bytes[0];
        o_result.addr_mid   = r_field_bytes[1];
        o_result.addr_low   = r_field_bytes[2];
        o_result.data_value = r_field_bytes[3];
    end

    always_comb begin
        n_in_frame      = r_in_frame;
        n_byte_index    = r_byte_index;
        n_ids_bad       = r_ids_bad;
        n_command_byte  = r_command_byte;
        n_field_bytes   = r_field_bytes;
        n_running_sum   = r_running_sum;
        n_previous_byte = r_previous_byte;
        o_fire          = 1'b0;
        if (i_accept) begin
            if (i_rx_byte == SX_START) begin
                n_in_frame      = 1'b1;
                n_byte_index    = 4'd1;
                n_ids_bad       = 1'b0;
                n_command_byte  = 8'd0;
                n_field_bytes   = '{default: 8'd0};
                n_running_sum   = 7'd0;
                n_previous_byte = SX_START;
            end else if (r_in_frame) begin
                if (i_rx_byte == SX_END) begin
                    o_fire     = 1'b1;
                    n_in_frame = 1'b0;
                end else begin
                    // The previous byte joins the sum once it is known not to be
                    // the checksum byte.
                    if (r_byte_index > SUM_FIRST) begin
                        n_running_sum = 7'(r_running_sum + r_previous_byte[6:0]);
                    end
                    if (r_byte_index == IDX_MANUF &&
                        i_rx_byte != {1'b0, i_cfg.manufacturer_id}) begin
                        n_ids_bad = 1'b1;
                    end
                    if (r_byte_index == IDX_MODEL &&
                        i_rx_byte != {1'b0, i_cfg.model_id}) begin
                        n_ids_bad = 1'b1;
                    end
                    if (r_byte_index == IDX_COMMAND) begin
                        n_command_byte = i_rx_byte;
                    end
                    if (r_byte_index >= SUM_FIRST && r_byte_index < MIN_END_INDEX) begin
                        n_field_bytes[field_sel] = i_rx_byte;
                    end
                    n_previous_byte = i_rx_byte;
                    if (r_byte_index != INDEX_MAX) begin
                        n_byte_index = 4'(r_byte_index + 4'd1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_byte_index    <= 4'd0;
            r_ids_bad       <= 1'b0;
            r_command_byte  <= 8'd0;
            r_field_bytes   <= '{default: 8'd0};
            r_running_sum   <= 7'd0;
            r_previous_byte <= 8'd0;
        end else begin
            r_in_frame      <= n_in_frame;
            r_byte_index    <= n_byte_index;
            r_ids_bad       <= n_ids_bad;
            r_command_byte  <= n_command_byte;
            r_field_bytes   <= n_field_bytes;
            r_running_sum   <= n_running_sum;
            r_previous_byte <= n_previous_byte;
        end
    end

endmodule

/* hdl/sysex_frame_validator_top.sv */
// Top level of the SysEx frame validator: configuration, frame tracker and result register.
//
//  Channel  Direction  Carries
//  i_rx     in         one received MIDI byte per word (rx_byte)
//  o_res    out        status, accepted, addr_high, addr_mid, addr_low, data_value
//  i_cfg    in         register index (0 manufacturer, 1 model, 2 set command) and data
//
// Every received byte is absorbed at its accepting edge, so one byte per clock is
// sustained while the spare slot is free. A closing byte's verdict is loaded at the
// accepting edge and offered from the next cycle on if the head was free or taken.
// Reset clears the frame state, empties the output stage and loads the register
// defaults (65, 20, 18).
// The output stage holds two words. Bytes keep flowing while one verdict waits on
// a stalled o_res; the input is refused only while a second verdict is parked
// behind it, and opens again in the cycle after the first word is handed over.
module sysex_frame_validator_top
    import sysex_fv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sysex_fv_byte_if.sink   i_rx,
    sysex_fv_result_if.source o_res,
    sysex_fv_cfg_if.sink    i_cfg
);

    // Configuration registers. Writes to an unused index are dropped.
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manufacturer_id <= RST_MANUF_ID;
            r_cfg.model_id        <= RST_MODEL_ID;
            r_cfg.set_command     <= RST_SET_CMD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MANUF_ID: r_cfg.manufacturer_id <= i_cfg.data;
                CFG_MODEL_ID: r_cfg.model_id        <= i_cfg.data;
                CFG_SET_CMD:  r_cfg.set_command     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Byte intake. A byte may enter whenever the spare slot of the output stage is
    // free, so a closing byte always has somewhere to land.
    logic    r_out_valid, n_out_valid;
    logic    r_spare_valid, n_spare_valid;
    t_result r_out;
    t_result r_spare;
    logic    load_out;
    logic    load_spare;
    logic    move_spare;
    logic    out_pop;
    logic    rx_accept;
    logic    fire;
    t_result result;

    assign i_rx.ready = !r_spare_valid;
    assign rx_accept  = i_rx.valid && i_rx.ready;
    assign out_pop    = r_out_valid && o_res.ready;

    sysex_fv_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (r_cfg),
        .o_fire    (fire),
        .o_result  (result)
    );

    // Output stage: the head word is offered on o_res, the spare word waits behind
    // it. A new verdict goes to the head when it is free or being taken, otherwise
    // to the spare slot; the spare word moves up once the head word is taken.
    always_comb begin
        n_out_valid   = r_out_valid;
        n_spare_valid = r_spare_valid;
        load_out      = 1'b0;
        load_spare    = 1'b0;
        move_spare    = 1'b0;
        if (out_pop) begin
            if (r_spare_valid) begin
                move_spare    = 1'b1;
                n_spare_valid = 1'b0;
            end else if (fire) begin
                load_out = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (fire) begin
            if (r_out_valid) begin
                load_spare    = 1'b1;
                n_spare_valid = 1'b1;
            end else begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
        end else begin
            r_out_valid   <= n_out_valid;
            r_spare_valid <= n_spare_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= result;
        end else if (move_spare) begin
            r_out <= r_spare;
        end
        if (load_spare) begin
            r_spare <= result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.accepted   = r_out.accepted;
    assign o_res.addr_high  = r_out.addr_high;
    assign o_res.addr_mid   = r_out.addr_mid;
    assign o_res.addr_low   = r_out.addr_low;
    assign o_res.data_value = r_out.data_value;

endmodule

/* tb/sysex_verdict_checker.sv */
// Checker for the SysEx frame validator: tracks frames, predicts each verdict and compares.
`timescale 1ns / 1ps

module sysex_verdict_checker
    import sysex_fv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic       i_byte_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  t_result    i_verdict,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_pending
);

    // Register copies, as last written over the configuration channel.
    logic [6:0] manuf_id;
    logic [6:0] model_id;
    logic [6:0] set_cmd;

    // Frame tracking state.
    logic       in_frame;
    logic [3:0] next_index;
    logic       ids_wrong;
    logic [7:0] cmd_seen;
    logic [7:0] captured [4];
    logic [6:0] sum7;
    logic [7:0] last_byte;

    t_result verdicts_due [$];
    int      mismatch_count = 0;

    task automatic absorb_byte(input logic [7:0] b);
        t_result    verdict;
        logic [6:0] want_sum;
        logic [2:0] st;
        if (b == SX_START) begin
            in_frame   = 1'b1;
            next_index = 4'd1;
            ids_wrong  = 1'b0;
            cmd_seen   = '0;
            foreach (captured[k]) captured[k] = '0;
            sum7       = '0;
            last_byte  = SX_START;
        end else if (in_frame) begin
            if (b == SX_END) begin
                want_sum = 7'd0 - sum7;
                if (next_index < MIN_END_INDEX) st = ST_TOO_SHORT;
                else if (ids_wrong) st = ST_BAD_IDS;
                else if (last_byte != {1'b0, want_sum}) st = ST_BAD_SUM;
                else if (cmd_seen != {1'b0, set_cmd}) st = ST_UNHANDLED;
                else st = ST_OK;
                verdict.status     = st;
                verdict.accepted   = (st == ST_OK);
                verdict.addr_high  = captured[0];
                verdict.addr_mid   = captured[1];
                verdict.addr_low   = captured[2];
                verdict.data_value = captured[3];
                verdicts_due = {verdicts_due, verdict};
                in_frame = 1'b0;
            end else begin
                // The previous byte joins the sum once it is known not to be the checksum.
                if (next_index >= SUM_FIRST + 4'd1) sum7 = sum7 + last_byte[6:0];
                if (next_index == IDX_MANUF && b != {1'b0, manuf_id}) ids_wrong = 1'b1;
                if (next_index == IDX_MODEL && b != {1'b0, model_id}) ids_wrong = 1'b1;
                if (next_index == IDX_COMMAND) cmd_seen = b;
                if (next_index >= SUM_FIRST && next_index < SUM_FIRST + 4'd4)
                    captured[2'(next_index - SUM_FIRST)] = b;
                last_byte = b;
                if (next_index < INDEX_MAX) next_index = next_index + 4'd1;
            end
        end
    endtask

    task automatic check_verdict(input t_result got);
        t_result want;
        if (verdicts_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] verdict with nothing pending: status=%0d acc=%0b addr=%h %h %h value=%h",
                         $time, got.status, got.accepted, got.addr_high, got.addr_mid,
                         got.addr_low, got.data_value);
        end else begin
            want = verdicts_due.pop_front();
            if (got.status !== want.status || got.accepted !== want.accepted ||
                got.addr_high !== want.addr_high || got.addr_mid !== want.addr_mid ||
                got.addr_low !== want.addr_low || got.data_value !== want.data_value) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("[%0t] verdict mismatch", $time);
                    $display("    expected status=%0d acc=%0b addr=%h %h %h value=%h",
                             want.status, want.accepted, want.addr_high, want.addr_mid,
                             want.addr_low, want.data_value);
                    $display("    actual   status=%0d acc=%0b addr=%h %h %h value=%h",
                             got.status, got.accepted, got.addr_high, got.addr_mid,
                             got.addr_low, got.data_value);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            manuf_id   = RST_MANUF_ID;
            model_id   = RST_MODEL_ID;
            set_cmd    = RST_SET_CMD;
            in_frame   = 1'b0;
            next_index = '0;
            ids_wrong  = 1'b0;
            cmd_seen   = '0;
            foreach (captured[k]) captured[k] = '0;
            sum7       = '0;
            last_byte  = '0;
            verdicts_due.delete();
        end else begin
            // A verdict handed over now was predicted earlier, so it is checked first.
            if (i_res_valid && i_res_ready) check_verdict(i_verdict);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MANUF_ID: manuf_id = i_cfg_data;
                    CFG_MODEL_ID: model_id = i_cfg_data;
                    CFG_SET_CMD:  set_cmd  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_byte_valid && i_byte_ready) absorb_byte(i_rx_byte);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= verdicts_due.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the SysEx frame validator testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
    import sysex_fv_pkg::*;

    // Index 3 addresses no register; writes to it must leave the block unchanged.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // 12 ns period, six nanoseconds high and six low.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sysex_fv_byte_if   rx_ch ();
    sysex_fv_result_if res_ch ();
    sysex_fv_cfg_if    cfg_ch ();

    int mismatches;
    int pending;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct;
    int stall_pct;

    // One long hold-off of the result channel, armed once by the stimulus.
    logic hold_go;
    logic hold_spent = 1'b0;
    int   hold_left  = 0;

    // Register values the stimulus builds its frames around.
    logic [6:0] cur_manuf;
    logic [6:0] cur_model;
    logic [6:0] cur_cmd;

    logic [7:0] frame_q [$];

    sysex_frame_validator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    sysex_verdict_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (rx_ch.valid),
        .i_byte_ready (rx_ch.ready),
        .i_rx_byte    (rx_ch.rx_byte),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_verdict    ({res_ch.status, res_ch.accepted, res_ch.addr_high, res_ch.addr_mid,
                        res_ch.addr_low, res_ch.data_value}),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_index  (cfg_ch.index),
        .i_cfg_data   (cfg_ch.data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Receiver side. Outside the hold-off, ready is drawn afresh every cycle; once the
    // hold-off is armed the channel stays closed until hold_left has counted down, so that
    // the block fills up and has to refuse further bytes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_go && !hold_spent) begin
            hold_spent   <= 1'b1;
            hold_left    <= 400;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // A run that has not finished by now has hung somewhere.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Adds one byte at the end of the frame under construction.
    function automatic void append_byte(input logic [7:0] b);
        frame_q = {frame_q, b};
    endfunction

    // Any byte that is not a frame marker.
    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v == SX_START || v == SX_END);
        return v;
    endfunction

    // A non-marker byte that differs from the given register value.
    function automatic logic [7:0] other_than(input logic [6:0] keep);
        logic [7:0] v;
        do v = plain_byte(); while (v == {1'b0, keep});
        return v;
    endfunction

    // Checksum byte for the frame bytes from position first to the current end.
    function automatic logic [7:0] checksum_from(input int first);
        logic [6:0] s;
        s = '0;
        for (int j = first; j < frame_q.size(); j++) s = s + frame_q[j][6:0];
        return {1'b0, 7'd0 - s};
    endfunction

    // Offers one byte, idling beforehand as the current mode dictates, and returns after
    // the first edge past which ready reads high. Valid is left high so that back-to-back bytes
    // need only one assignment per edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[j]) send_byte(frame_q[j]);
    endtask

    // Closes the byte channel and waits until every predicted verdict has come out, then
    // idles on for any frame that was still being tracked without a verdict.
    task automatic drain_block();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [6:0] m, input logic [6:0] mo, input logic [6:0] c,
                                 input bit spare);
        write_reg(CFG_MANUF_ID, m);
        write_reg(CFG_MODEL_ID, mo);
        write_reg(CFG_SET_CMD, c);
        if (spare) write_reg(CFG_SPARE, 7'($urandom_range(127)));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        cur_manuf = m;
        cur_model = mo;
        cur_cmd   = c;
    endtask

    task automatic set_mode(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 87; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 87; end
            default: begin idle_pct = 30; stall_pct <= 30; end
        endcase
    endtask

    // Builds one random frame into frame_q. Most frames are well formed data set
    // messages; the rest carry one fault each: a wrong manufacturer or model byte, a
    // corrupted checksum, a different command, a truncated frame, a long frame that
    // drives the index into saturation, bytes with bit 7 set, a frame that is restarted
    // by a fresh start byte, or plain garbage. Stray bytes between frames come now and then.
    task automatic compose_frame();
        int         kind;
        int         n;
        int         base;
        int         first;
        int         k;
        logic [7:0] cs;
        frame_q.delete();
        kind = $urandom_range(99);
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, 3))
                append_byte(($urandom_range(3) == 0) ? SX_END : plain_byte());
        if (kind >= 90 && kind < 95) begin
            append_byte(SX_START);
            repeat ($urandom_range(0, 6)) append_byte(plain_byte());
        end
        if (kind >= 95) begin
            append_byte(SX_START);
            repeat ($urandom_range(0, 16)) append_byte(plain_byte());
            append_byte(SX_END);
            return;
        end
        base = frame_q.size();
        append_byte(SX_START);
        append_byte((kind >= 45 && kind <= 52) ? other_than(cur_manuf) : {1'b0, cur_manuf});
        append_byte(($urandom_range(3) == 0) ? plain_byte() : 8'($urandom_range(127)));
        append_byte((kind >= 53 && kind <= 58) ? other_than(cur_model) : {1'b0, cur_model});
        append_byte((kind >= 67 && kind <= 72) ? other_than(cur_cmd) : {1'b0, cur_cmd});
        if (kind >= 79 && kind <= 84) n = $urandom_range(5, 12);
        else n = ($urandom_range(9) == 0) ? 3 : 4;
        first = frame_q.size();
        repeat (n) append_byte(8'($urandom_range(127)));
        if (kind >= 85 && kind <= 89) begin
            do cs = plain_byte(); while (!cs[7]);
            frame_q[first + $urandom_range(n - 1)] = cs;
        end
        cs = checksum_from(first);
        if (kind >= 59 && kind <= 66) cs = cs ^ {1'b0, 7'($urandom_range(1, 127))};
        // A checksum byte with bit 7 set can never match, whatever the sum.
        if (kind >= 85 && kind <= 89 && $urandom_range(1) == 1 &&
            (cs | 8'h80) != SX_START && (cs | 8'h80) != SX_END)
            cs = cs | 8'h80;
        append_byte(cs);
        if (kind >= 73 && kind <= 78) begin
            k = $urandom_range(1, 8);
            while (frame_q.size() > base + k) void'(frame_q.pop_back());
        end
        append_byte(SX_END);
    endtask

    initial begin
        int         sent;
        logic [6:0] m;
        logic [6:0] mo;
        logic [6:0] c;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_MANUF_ID;
        cfg_ch.data   = '0;
        hold_go       = 1'b0;
        i_rst_n       = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        cur_manuf     = RST_MANUF_ID;
        cur_model     = RST_MODEL_ID;
        cur_cmd       = RST_SET_CMD;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the reset register values. A lone end byte and a stray
        // byte outside any frame are ignored, a start byte inside a frame restarts it, and
        // the bare start-end pair is too short with every captured field still zero.
        frame_q = '{SX_END, 8'hFF, SX_START, {1'b0, RST_MANUF_ID}, SX_START, SX_END};
        send_frame();
        // The shortest acceptable data set message, with extreme data bytes; its value
        // field is the checksum byte itself.
        frame_q = '{SX_START, {1'b0, RST_MANUF_ID}, 8'h7F, {1'b0, RST_MODEL_ID},
                    {1'b0, RST_SET_CMD}, 8'h7F, 8'h00, 8'h7F};
        append_byte(checksum_from(5));
        append_byte(SX_END);
        send_frame();
        // An address byte with bit 7 set only counts modulo 128 in the sum.
        frame_q = '{SX_START, {1'b0, RST_MANUF_ID}, 8'h00, {1'b0, RST_MODEL_ID},
                    {1'b0, RST_SET_CMD}, 8'hFF, 8'h00, 8'h00, 8'h00};
        append_byte(checksum_from(5));
        append_byte(SX_END);
        send_frame();

        // Random part: eight phases, each with a register setting and an idling mode; phases 0 and 4 share both.
        for (int p = 0; p < 8; p++) begin
            drain_block();
            case (p)
                1: begin m = 7'd0;   mo = 7'd0;   c = 7'd0;   end
                2: begin m = 7'd127; mo = 7'd127; c = 7'd127; end
                4: begin m = RST_MANUF_ID; mo = RST_MODEL_ID; c = RST_SET_CMD; end
                6: begin m = 7'd0;   mo = 7'd127; c = 7'd0;   end
                7: begin m = 7'd127; mo = 7'd0;   c = 7'd127; end
                default: begin
                    m  = 7'($urandom_range(127));
                    mo = 7'($urandom_range(127));
                    c  = 7'($urandom_range(127));
                end
            endcase
            // Phase 0 keeps the reset values so the defaults are exercised too.
            if (p != 0) apply_setting(m, mo, c, p == 3);
            set_mode(p % 4);
            // In phase 4, which runs without idling, the result channel is shut for a long stretch
            // while bytes keep coming, so the block has to push back on its input.
            if (p == 4) hold_go <= 1'b1;
            sent = 0;
            while (sent < 240) begin
                compose_frame();
                send_frame();
                sent += frame_q.size();
            end
        end

        drain_block();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
